// ----- design/bll_pkg.sv -----
// Package for the bounded linked list engine: pool sizes, derived widths,
// request and status codes, and the value conversion functions.
// No dependencies; every other design file refers to it by scoped names.
package bll_pkg;

	localparam int POOL_DEPTH = 256;
	localparam int VALUE_BITS = 32;

	localparam int IDX_W  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
	localparam int MODE_W = 3;
	localparam int STAT_W = 2;
	localparam int WORD_W = 32;

	localparam logic [MODE_W-1:0] MODE_PUSH_HEAD = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_TAIL = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP_HEAD  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_TAIL  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DELETE    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_SEARCH    = 3'd5;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	// Sign-extends the port word and keeps the stored width.
	function automatic value_t value_to_store(input logic [WORD_W-1:0] raw);
		logic [63:0] wide;
		wide = {{32{raw[WORD_W-1]}}, raw};
		return wide[VALUE_BITS-1:0];
	endfunction

	// Sign-extends a stored value back to the port word.
	function automatic logic [WORD_W-1:0] value_to_port(input value_t v);
		logic signed [63:0] wide;
		wide = 64'($signed(v));
		return wide[WORD_W-1:0];
	endfunction

endpackage

// ----- design/bll_if.sv -----
// Valid/ready channel interfaces for the request and response items of the
// bounded linked list engine. Depends on bll_pkg for the mode, status, word and count widths.
interface bll_req_if;
	logic                             valid;
	logic                             ready;
	logic [bll_pkg::MODE_W-1:0]       mode;
	logic signed [bll_pkg::WORD_W-1:0] value;

	modport source (output valid, output mode, output value, input ready);
	modport sink   (input valid, input mode, input value, output ready);
endinterface

interface bll_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [bll_pkg::STAT_W-1:0]        status;
	logic signed [bll_pkg::WORD_W-1:0] value_out;
	logic [bll_pkg::CNT_W-1:0]         count;

	modport source (output valid, output status, output value_out, output count, input ready);
	modport sink   (input valid, input status, input value_out, input count, output ready);
endinterface

// ----- design/bounded_linked_list_engine.sv -----
// Bounded linked list engine: top level with node memories and sequencer.
// Depends on bll_pkg and the channel interfaces in bll_if.sv.
//
// The engine keeps an ordered list of signed words as linked nodes in a pool of
// bll_pkg::POOL_DEPTH entries. Each request item pushes at the head or tail, pops
// the head or tail, deletes the first node holding a value, or searches for a
// value (an unknown mode changes nothing), and produces exactly one response
// item carrying a status, the popped value (zero otherwise) and the list length
// after the request. Node values and links sit in two synchronous memories with
// a registered read; a single read port walks the chain one node per cycle, and
// this chain walk sets how long a tail pop, a delete or a search takes. A new
// request item is accepted once the sequencer is back in idle, even while the
// previous response item still waits in the output register. The memories need
// no clearing after reset: a node comes from the free list when it holds one,
// else from a fresh counter, and every node is written before it is read, so no
// unwritten entry is ever read.
module bounded_linked_list_engine (
	input  logic      clk,
	input  logic      arst_n,
	bll_req_if.sink   req,
	bll_rsp_if.source rsp
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_TAKE  = 4'd1;
	localparam logic [3:0] ST_PUSH  = 4'd2;
	localparam logic [3:0] ST_LINKT = 4'd3;
	localparam logic [3:0] ST_POPH  = 4'd4;
	localparam logic [3:0] ST_TPOP  = 4'd5;
	localparam logic [3:0] ST_TWALK = 4'd6;
	localparam logic [3:0] ST_TFIN  = 4'd7;
	localparam logic [3:0] ST_TCLR  = 4'd8;
	localparam logic [3:0] ST_SCAN  = 4'd9;
	localparam logic [3:0] ST_DEL   = 4'd10;
	localparam logic [3:0] ST_DGIVE = 4'd11;
	localparam logic [3:0] ST_DONE  = 4'd12;

	localparam bll_pkg::cnt_t DEPTH_CNT = bll_pkg::CNT_W'(bll_pkg::POOL_DEPTH);
	localparam bll_pkg::cnt_t ONE_CNT   = bll_pkg::CNT_W'(1);
	localparam bll_pkg::cnt_t TWO_CNT   = bll_pkg::CNT_W'(2);

	// Control state.
	logic [3:0]      state_q;
	bll_pkg::idx_t   head_q;
	bll_pkg::idx_t   tail_q;
	bll_pkg::cnt_t   count_q;
	bll_pkg::idx_t   free_head_q;
	bll_pkg::cnt_t   free_count_q;
	bll_pkg::cnt_t   fresh_q;
	logic            rsp_valid_q;

	// Per-request working registers.
	logic [bll_pkg::MODE_W-1:0] mode_q;
	bll_pkg::value_t            val_q;
	bll_pkg::idx_t              node_q;
	bll_pkg::idx_t              prev_q;
	bll_pkg::cnt_t              i_q;
	logic [bll_pkg::STAT_W-1:0] res_status_q;
	logic [bll_pkg::WORD_W-1:0] res_value_q;

	// Output register.
	logic [bll_pkg::STAT_W-1:0] rsp_status_q;
	logic [bll_pkg::WORD_W-1:0] rsp_value_q;
	bll_pkg::cnt_t              rsp_count_q;

	// Node memories and their registered read data.
	bll_pkg::value_t node_value_mem [bll_pkg::POOL_DEPTH];
	bll_pkg::idx_t   node_link_mem  [bll_pkg::POOL_DEPTH];
	bll_pkg::value_t rv_q;
	bll_pkg::idx_t   rl_q;

	logic            rd_en;
	bll_pkg::idx_t   rd_addr;
	logic            val_we;
	logic            link_we;
	bll_pkg::idx_t   link_waddr;
	bll_pkg::idx_t   link_wdata;

	logic            accept;
	logic            match;
	logic            more;
	logic            rsp_load;

	assign req.ready     = (state_q == ST_IDLE);
	assign accept        = req.valid && req.ready;
	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.value_out = rsp_value_q;
	assign rsp.count     = rsp_count_q;

	// The value read last cycle matches the request value.
	assign match    = (rv_q == val_q);
	// Another node remains to be visited after the current one.
	assign more     = ((i_q + ONE_CNT) < count_q);
	assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	// Memory port control. The read address follows the state: in walking states
	// it is taken straight from the link just read, so one node is visited per cycle.
	always_comb begin
		rd_en      = 1'b0;
		rd_addr    = head_q;
		val_we     = 1'b0;
		link_we    = 1'b0;
		link_waddr = node_q;
		link_wdata = free_head_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.mode)
						bll_pkg::MODE_PUSH_HEAD, bll_pkg::MODE_PUSH_TAIL: begin
							rd_en   = (free_count_q != '0);
							rd_addr = free_head_q;
						end
						bll_pkg::MODE_POP_TAIL: begin
							rd_en   = (count_q != '0);
							rd_addr = tail_q;
						end
						bll_pkg::MODE_POP_HEAD, bll_pkg::MODE_DELETE,
						bll_pkg::MODE_SEARCH: begin
							rd_en   = (count_q != '0);
							rd_addr = head_q;
						end
						default: begin
							rd_en = 1'b0;
						end
					endcase
				end
			end
			ST_PUSH: begin
				val_we     = 1'b1;
				link_we    = 1'b1;
				link_waddr = node_q;
				link_wdata = (mode_q == bll_pkg::MODE_PUSH_HEAD) ? head_q : '0;
			end
			ST_LINKT: begin
				link_we    = 1'b1;
				link_waddr = prev_q;
				link_wdata = node_q;
			end
			ST_POPH, ST_TFIN, ST_DGIVE: begin
				link_we = 1'b1;
			end
			ST_TPOP: begin
				rd_en   = (count_q > TWO_CNT);
				rd_addr = head_q;
			end
			ST_TWALK: begin
				rd_en   = more;
				rd_addr = rl_q;
			end
			ST_TCLR: begin
				link_we    = 1'b1;
				link_waddr = prev_q;
				link_wdata = '0;
			end
			ST_SCAN: begin
				rd_en   = !match && more;
				rd_addr = rl_q;
			end
			ST_DEL: begin
				link_we = 1'b1;
				if (i_q != '0) begin
					link_waddr = prev_q;
					link_wdata = rl_q;
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (val_we) begin
			node_value_mem[node_q] <= val_q;
		end
		if (rd_en) begin
			rv_q <= node_value_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			node_link_mem[link_waddr] <= link_wdata;
		end
		if (rd_en) begin
			rl_q <= node_link_mem[rd_addr];
		end
	end

	// Sequencer and list bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			free_head_q  <= '0;
			free_count_q <= '0;
			fresh_q      <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.mode)
							bll_pkg::MODE_PUSH_HEAD, bll_pkg::MODE_PUSH_TAIL: begin
								if (free_count_q != '0) begin
									state_q <= ST_TAKE;
								end else if (fresh_q < DEPTH_CNT) begin
									fresh_q <= fresh_q + ONE_CNT;
									state_q <= ST_PUSH;
								end else begin
									state_q <= ST_DONE;
								end
							end
							bll_pkg::MODE_POP_HEAD: begin
								state_q <= (count_q == '0) ? ST_DONE : ST_POPH;
							end
							bll_pkg::MODE_POP_TAIL: begin
								state_q <= (count_q == '0) ? ST_DONE : ST_TPOP;
							end
							bll_pkg::MODE_DELETE, bll_pkg::MODE_SEARCH: begin
								state_q <= (count_q == '0) ? ST_DONE : ST_SCAN;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_TAKE: begin
					free_head_q  <= rl_q;
					free_count_q <= free_count_q - ONE_CNT;
					state_q      <= ST_PUSH;
				end
				ST_PUSH: begin
					count_q <= count_q + ONE_CNT;
					if (mode_q == bll_pkg::MODE_PUSH_HEAD) begin
						head_q <= node_q;
						if (count_q == '0) begin
							tail_q <= node_q;
						end
						state_q <= ST_DONE;
					end else begin
						tail_q <= node_q;
						if (count_q == '0) begin
							head_q  <= node_q;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_LINKT;
						end
					end
				end
				ST_LINKT: begin
					state_q <= ST_DONE;
				end
				ST_POPH: begin
					free_head_q  <= node_q;
					free_count_q <= free_count_q + ONE_CNT;
					count_q      <= count_q - ONE_CNT;
					if (count_q == ONE_CNT) begin
						head_q <= '0;
						tail_q <= '0;
					end else begin
						head_q <= rl_q;
					end
					state_q <= ST_DONE;
				end
				ST_TPOP: begin
					state_q <= (count_q > TWO_CNT) ? ST_TWALK : ST_TFIN;
				end
				ST_TWALK: begin
					if (!more) begin
						state_q <= ST_TFIN;
					end
				end
				ST_TFIN: begin
					free_head_q  <= node_q;
					free_count_q <= free_count_q + ONE_CNT;
					count_q      <= count_q - ONE_CNT;
					if (count_q == ONE_CNT) begin
						head_q  <= '0;
						tail_q  <= '0;
						state_q <= ST_DONE;
					end else begin
						tail_q  <= prev_q;
						state_q <= ST_TCLR;
					end
				end
				ST_TCLR: begin
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (match) begin
						state_q <= (mode_q == bll_pkg::MODE_DELETE) ? ST_DEL : ST_DONE;
					end else if (!more) begin
						state_q <= ST_DONE;
					end
				end
				ST_DEL: begin
					if (i_q == '0) begin
						free_head_q  <= node_q;
						free_count_q <= free_count_q + ONE_CNT;
						count_q      <= count_q - ONE_CNT;
						if (count_q == ONE_CNT) begin
							head_q <= '0;
							tail_q <= '0;
						end else begin
							head_q <= rl_q;
						end
						state_q <= ST_DONE;
					end else begin
						if (i_q == (count_q - ONE_CNT)) begin
							tail_q <= prev_q;
						end
						state_q <= ST_DGIVE;
					end
				end
				ST_DGIVE: begin
					free_head_q  <= node_q;
					free_count_q <= free_count_q + ONE_CNT;
					count_q      <= count_q - ONE_CNT;
					state_q      <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers and the output payload.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mode_q       <= req.mode;
					val_q        <= bll_pkg::value_to_store(req.value);
					res_status_q <= bll_pkg::STAT_OK;
					res_value_q  <= '0;
					i_q          <= '0;
					prev_q       <= '0;
					case (req.mode)
						bll_pkg::MODE_PUSH_HEAD, bll_pkg::MODE_PUSH_TAIL: begin
							if (free_count_q != '0) begin
								node_q <= free_head_q;
							end else if (fresh_q < DEPTH_CNT) begin
								node_q <= fresh_q[bll_pkg::IDX_W-1:0];
							end else begin
								res_status_q <= bll_pkg::STAT_FULL;
							end
						end
						bll_pkg::MODE_POP_TAIL: begin
							if (count_q == '0) begin
								res_status_q <= bll_pkg::STAT_EMPTY;
							end
							node_q <= tail_q;
						end
						bll_pkg::MODE_POP_HEAD, bll_pkg::MODE_DELETE,
						bll_pkg::MODE_SEARCH: begin
							if (count_q == '0) begin
								res_status_q <= bll_pkg::STAT_EMPTY;
							end
							node_q <= head_q;
						end
						default: begin
							res_status_q <= bll_pkg::STAT_OK;
						end
					endcase
				end
			end
			ST_PUSH: begin
				// Old tail, which a tail push links to the new node next.
				prev_q <= tail_q;
			end
			ST_POPH: begin
				res_value_q <= bll_pkg::value_to_port(rv_q);
			end
			ST_TPOP: begin
				res_value_q <= bll_pkg::value_to_port(rv_q);
				prev_q      <= head_q;
				i_q         <= TWO_CNT;
			end
			ST_TWALK: begin
				prev_q <= rl_q;
				i_q    <= i_q + ONE_CNT;
			end
			ST_SCAN: begin
				if (!match) begin
					if (more) begin
						prev_q <= node_q;
						node_q <= rl_q;
						i_q    <= i_q + ONE_CNT;
					end else begin
						res_status_q <= bll_pkg::STAT_NOT_FOUND;
					end
				end
			end
			ST_DONE: begin
				if (rsp_load) begin
					rsp_status_q <= res_status_q;
					rsp_value_q  <= res_value_q;
					rsp_count_q  <= count_q;
				end
			end
			default: begin
				i_q <= i_q;
			end
		endcase
	end

	// Every node handed out is either on the list or on the free list.
	a_node_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (count_q + free_count_q == fresh_q))
		else $error("node accounting out of balance");

	// An empty list leaves head and tail at zero.
	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && count_q == '0) |-> (head_q == '0 && tail_q == '0))
		else $error("empty list with stale head or tail");

	// A full report only when the pool really is exhausted.
	a_full_report: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_load && res_status_q == bll_pkg::STAT_FULL)
		|-> (free_count_q == '0 && fresh_q == DEPTH_CNT))
		else $error("pool full reported with nodes left");

	// The scan never visits more nodes than the list holds.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (i_q < count_q))
		else $error("scan ran past the end of the list");

	// A loaded response is offered in the next cycle with the list length.
	a_rsp_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |=> (rsp_valid_q && rsp_count_q == $past(count_q)))
		else $error("response not offered after load");

endmodule
